FILE: hdl/bech32_checksum_engine_assert.svh
// Assertion helpers shared by the engine modules.
// Both expect clk and rst_n in scope.
`ifndef BECH32_CHECKSUM_ENGINE_ASSERT_SVH
`define BECH32_CHECKSUM_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define BCE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bce: same-cycle check failed");

// Next-cycle implication.
`define BCE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bce: next-cycle check failed");

`endif

FILE: hdl/bce_pkg.sv
package bce_pkg;

    localparam int MODE_W     = 3;
    localparam int CHAR_W     = 7;
    localparam int SYM_W      = 5;
    localparam int STATUS_W   = 3;
    localparam int CHK_W      = 30;
    localparam int PFX_CNT_W  = 7;
    localparam int DATA_CNT_W = 8;
    localparam int PREFIX_MAX = 84;
    localparam int PFX_ADDR_W = $clog2(PREFIX_MAX);
    localparam int FIN_STEPS  = 6;
    localparam int STEP_W     = 3;
    localparam int MIN_DATA   = 6;

    localparam logic [CHK_W-1:0] GEN [5] = '{
        30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
    };

    localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    typedef enum logic [MODE_W-1:0] {
        MODE_START       = 3'd0,
        MODE_PREFIX      = 3'd1,
        MODE_END_PREFIX  = 3'd2,
        MODE_DATA_VALUE  = 3'd3,
        MODE_DATA_CHAR   = 3'd4,
        MODE_FINISH_ENC  = 3'd5,
        MODE_FINISH_VER  = 3'd6,
        MODE_NONE        = 3'd7
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_BAD_CHAR    = 3'd1,
        ST_MISMATCH    = 3'd2,
        ST_SHORT       = 3'd3,
        ST_PREFIX_LONG = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HOLD,
        S_WALK,
        S_FIN_FEED,
        S_FIN_EMIT
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic accept;
        logic use_held;
        logic exec;
        logic walk_start;
        logic walk_step;
        logic walk_emit;
        logic fin_load;
        logic fin_feed;
        logic fin_emit;
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic slot_free;
        logic walk_done;
        logic step_last;
    } dp_stat_t;

    // One BCH polymod step.
    function automatic logic [CHK_W-1:0] feed(logic [CHK_W-1:0] chk, logic [SYM_W-1:0] v);
        logic [CHK_W-1:0] n;
        n = {chk[CHK_W-SYM_W-1:0], SYM_W'(0)} ^ CHK_W'(v);
        for (int i = 0; i < 5; i++) begin
            if (chk[CHK_W-SYM_W+i]) begin
                n = n ^ GEN[i];
            end
        end
        return n;
    endfunction

    function automatic logic [CHAR_W-1:0] sym_char(logic [SYM_W-1:0] s);
        logic [7:0] b;
        b = CHARSET[8*(31 - int'(s)) +: 8];
        return b[CHAR_W-1:0];
    endfunction

    // {hit, index}
    function automatic logic [SYM_W:0] sym_lookup(logic [CHAR_W-1:0] c);
        logic [SYM_W:0] r;
        r = '0;
        for (int i = 0; i < 32; i++) begin
            if (CHARSET[8*(31 - i) +: 8] == {1'b0, c}) begin
                r = {1'b1, SYM_W'(i)};
            end
        end
        return r;
    endfunction

endpackage

FILE: hdl/bce_if.sv
interface bce_in_if;
    logic                          valid;
    logic                          ready;
    logic [bce_pkg::MODE_W-1:0]    mode;
    logic [bce_pkg::CHAR_W-1:0]    char_in;
    logic [bce_pkg::SYM_W-1:0]     value_in;

    modport source (output valid, output mode, output char_in, output value_in, input ready);
    modport sink   (input valid, input mode, input char_in, input value_in, output ready);
endinterface

interface bce_out_if;
    logic                          valid;
    logic                          ready;
    logic [bce_pkg::CHAR_W-1:0]    char_out;
    logic [bce_pkg::SYM_W-1:0]     value_out;
    logic [bce_pkg::STATUS_W-1:0]  status;
    logic                          last;

    modport source (output valid, output char_out, output value_out, output status,
                    output last, input ready);
    modport sink   (input valid, input char_out, input value_out, input status,
                    input last, output ready);
endinterface

FILE: hdl/bce_ram.sv
module bce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/bce_datapath.sv
`include "bech32_checksum_engine_assert.svh"

module bce_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bce_pkg::ctrl_cmd_t           cmd,
    input  logic [bce_pkg::MODE_W-1:0]   in_mode,
    input  logic [bce_pkg::CHAR_W-1:0]   in_char,
    input  logic [bce_pkg::SYM_W-1:0]    in_value,
    input  logic                         out_ready,
    output bce_pkg::dp_stat_t            stat,
    output logic                         out_valid,
    output logic [bce_pkg::CHAR_W-1:0]   out_char,
    output logic [bce_pkg::SYM_W-1:0]    out_value,
    output logic [bce_pkg::STATUS_W-1:0] out_status,
    output logic                         out_last
);
    import bce_pkg::*;

    // control state
    logic [CHK_W-1:0]      check_reg,     check_next;
    logic [PFX_CNT_W-1:0]  pfx_cnt_reg,   pfx_cnt_next;
    logic [DATA_CNT_W-1:0] data_cnt_reg,  data_cnt_next;
    logic                  err_reg,       err_next;
    logic [PFX_CNT_W-1:0]  walk_idx_reg,  walk_idx_next;
    logic [STEP_W-1:0]     step_reg,      step_next;
    logic                  out_valid_reg, out_valid_next;

    // payload
    logic [MODE_W-1:0]     held_mode_reg;
    logic [CHAR_W-1:0]     held_char_reg;
    logic [SYM_W-1:0]      held_value_reg;
    logic [CHK_W-1:0]      fin_reg,       fin_next;
    logic [CHAR_W-1:0]     out_char_reg,  out_char_next;
    logic [SYM_W-1:0]      out_value_reg, out_value_next;
    logic [STATUS_W-1:0]   out_stat_reg,  out_stat_next;
    logic                  out_last_reg,  out_last_next;

    logic                  slot_free;
    logic                  load_out;
    mode_t                 item_mode;
    logic [CHAR_W-1:0]     item_char;
    logic [SYM_W-1:0]      item_value;
    logic [SYM_W:0]        hit;
    logic [SYM_W-1:0]      fin_sym;
    logic                  pfx_wr;
    logic                  rd_en;
    logic [SYM_W-1:0]      rd_data;

    assign slot_free  = !out_valid_reg || out_ready;
    assign item_mode  = mode_t'(cmd.use_held ? held_mode_reg : in_mode);
    assign item_char  = cmd.use_held ? held_char_reg  : in_char;
    assign item_value = cmd.use_held ? held_value_reg : in_value;
    assign hit        = sym_lookup(item_char);
    assign fin_sym    = fin_reg[CHK_W-1 -: SYM_W];

    assign pfx_wr = cmd.exec && (item_mode == MODE_PREFIX) && (pfx_cnt_reg < PFX_CNT_W'(PREFIX_MAX));
    assign rd_en  = cmd.walk_start || (cmd.walk_step && (walk_idx_next != pfx_cnt_reg));

    bce_ram #(
        .WIDTH (SYM_W),
        .DEPTH (PREFIX_MAX)
    ) u_pfx_ram (
        .clk     (clk),
        .wr_en   (pfx_wr),
        .wr_addr (pfx_cnt_reg[PFX_ADDR_W-1:0]),
        .wr_data (item_char[SYM_W-1:0]),
        .rd_en   (rd_en),
        .rd_addr (walk_idx_next[PFX_ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        check_next     = check_reg;
        pfx_cnt_next   = pfx_cnt_reg;
        data_cnt_next  = data_cnt_reg;
        err_next       = err_reg;
        walk_idx_next  = walk_idx_reg;
        step_next      = step_reg;
        fin_next       = fin_reg;
        load_out       = 1'b0;
        out_char_next  = out_char_reg;
        out_value_next = out_value_reg;
        out_stat_next  = out_stat_reg;
        out_last_next  = out_last_reg;

        if (cmd.exec)
        begin
            load_out       = 1'b1;
            out_char_next  = '0;
            out_value_next = '0;
            out_stat_next  = ST_OK;
            out_last_next  = 1'b1;
            unique case (item_mode)
                MODE_START:
                begin
                    check_next    = CHK_W'(1);
                    pfx_cnt_next  = '0;
                    data_cnt_next = '0;
                    err_next      = 1'b0;
                end
                MODE_PREFIX:
                begin
                    if (pfx_wr)
                    begin
                        check_next   = feed(check_reg, SYM_W'(item_char[CHAR_W-1:SYM_W]));
                        pfx_cnt_next = pfx_cnt_reg + PFX_CNT_W'(1);
                    end
                    else
                    begin
                        err_next      = 1'b1;
                        out_stat_next = ST_PREFIX_LONG;
                    end
                end
                MODE_DATA_VALUE:
                begin
                    check_next     = feed(check_reg, item_value);
                    out_char_next  = sym_char(item_value);
                    out_value_next = item_value;
                    if (data_cnt_reg != '1)
                    begin
                        data_cnt_next = data_cnt_reg + DATA_CNT_W'(1);
                    end
                end
                MODE_DATA_CHAR:
                begin
                    out_char_next = item_char;
                    if (hit[SYM_W])
                    begin
                        check_next     = feed(check_reg, hit[SYM_W-1:0]);
                        out_value_next = hit[SYM_W-1:0];
                        if (data_cnt_reg != '1)
                        begin
                            data_cnt_next = data_cnt_reg + DATA_CNT_W'(1);
                        end
                    end
                    else
                    begin
                        err_next      = 1'b1;
                        out_stat_next = ST_BAD_CHAR;
                    end
                end
                MODE_FINISH_VER:
                begin
                    if (err_reg)
                    begin
                        out_stat_next = ST_BAD_CHAR;
                    end
                    else if (data_cnt_reg < DATA_CNT_W'(MIN_DATA))
                    begin
                        out_stat_next = ST_SHORT;
                    end
                    else if (check_reg != CHK_W'(1))
                    begin
                        out_stat_next = ST_MISMATCH;
                    end
                end
                default:
                begin
                    load_out = 1'b0;
                end
            endcase
        end

        if (cmd.walk_start)
        begin
            check_next    = feed(check_reg, '0);
            walk_idx_next = '0;
        end

        if (cmd.walk_step)
        begin
            check_next    = feed(check_reg, rd_data);
            walk_idx_next = walk_idx_reg + PFX_CNT_W'(1);
        end

        if (cmd.walk_emit)
        begin
            load_out       = 1'b1;
            out_char_next  = '0;
            out_value_next = '0;
            out_stat_next  = ST_OK;
            out_last_next  = 1'b1;
        end

        if (cmd.fin_load)
        begin
            fin_next  = check_reg;
            step_next = '0;
        end

        if (cmd.fin_feed)
        begin
            // sixth zero also folds in the final xor 1
            fin_next  = feed(fin_reg, '0) ^ CHK_W'(stat.step_last);
            step_next = stat.step_last ? '0 : step_reg + STEP_W'(1);
        end

        if (cmd.fin_emit)
        begin
            load_out       = 1'b1;
            out_char_next  = sym_char(fin_sym);
            out_value_next = fin_sym;
            out_stat_next  = err_reg ? ST_BAD_CHAR : ST_OK;
            out_last_next  = stat.step_last;
            fin_next       = {fin_reg[CHK_W-SYM_W-1:0], SYM_W'(0)};
            step_next      = step_reg + STEP_W'(1);
        end

        out_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_reg     <= CHK_W'(1);
            pfx_cnt_reg   <= '0;
            data_cnt_reg  <= '0;
            err_reg       <= 1'b0;
            walk_idx_reg  <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            check_reg     <= check_next;
            pfx_cnt_reg   <= pfx_cnt_next;
            data_cnt_reg  <= data_cnt_next;
            err_reg       <= err_next;
            walk_idx_reg  <= walk_idx_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            held_mode_reg  <= in_mode;
            held_char_reg  <= in_char;
            held_value_reg <= in_value;
        end
        fin_reg       <= fin_next;
        out_char_reg  <= out_char_next;
        out_value_reg <= out_value_next;
        out_stat_reg  <= out_stat_next;
        out_last_reg  <= out_last_next;
    end

    assign stat.slot_free = slot_free;
    assign stat.walk_done = (walk_idx_reg == pfx_cnt_reg);
    assign stat.step_last = (step_reg == STEP_W'(FIN_STEPS - 1));

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_stat_reg;
    assign out_last   = out_last_reg;

    // a pending result is never overwritten
    `BCE_ASSERT_IMP(a_no_overwrite, load_out && out_valid_reg, out_ready)
    // prefix walk stays inside the written entries
    `BCE_ASSERT_IMP(a_walk_in_range, cmd.walk_step, walk_idx_reg < pfx_cnt_reg)
    // start leaves a fresh checksum
    `BCE_ASSERT_NXT(a_start_clears, cmd.exec && (item_mode == MODE_START),
                    (check_reg == CHK_W'(1)) && (data_cnt_reg == '0) && !err_reg)

endmodule

FILE: hdl/bce_ctrl.sv
`include "bech32_checksum_engine_assert.svh"

module bce_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [bce_pkg::MODE_W-1:0] in_mode,
    input  bce_pkg::dp_stat_t          stat,
    output logic                       in_ready,
    output bce_pkg::ctrl_cmd_t         cmd
);
    import bce_pkg::*;

    state_t state_reg, state_next;
    mode_t  mode;

    assign mode = mode_t'(in_mode);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    unique case (mode)
                        MODE_NONE:
                        begin
                        end
                        MODE_END_PREFIX:
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = S_WALK;
                        end
                        MODE_FINISH_ENC:
                        begin
                            cmd.fin_load = 1'b1;
                            state_next   = S_FIN_FEED;
                        end
                        default:
                        begin
                            // single-result item; park it if the output is busy
                            if (stat.slot_free)
                            begin
                                cmd.exec = 1'b1;
                            end
                            else
                            begin
                                state_next = S_HOLD;
                            end
                        end
                    endcase
                end
            end
            S_HOLD:
            begin
                if (stat.slot_free)
                begin
                    cmd.use_held = 1'b1;
                    cmd.exec     = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (!stat.walk_done)
                begin
                    cmd.walk_step = 1'b1;
                end
                else if (stat.slot_free)
                begin
                    cmd.walk_emit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_FIN_FEED:
            begin
                cmd.fin_feed = 1'b1;
                if (stat.step_last)
                begin
                    state_next = S_FIN_EMIT;
                end
            end
            S_FIN_EMIT:
            begin
                if (stat.slot_free)
                begin
                    cmd.fin_emit = 1'b1;
                    if (stat.step_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // parked item waits for the output register
    `BCE_ASSERT_NXT(a_hold_waits, (state_reg == S_HOLD) && !stat.slot_free,
                    state_reg == S_HOLD)
    // sixth checksum symbol ends the finish sequence
    `BCE_ASSERT_NXT(a_fin_ends, (state_reg == S_FIN_EMIT) && stat.slot_free && stat.step_last,
                    state_reg == S_IDLE)

endmodule

FILE: hdl/bech32_checksum_engine.sv
// Bech32 checksum engine. Each input transaction carries a mode (start, prefix
// character, end of prefix, data value, data character, finish-encode,
// finish-verify) and drives the 30-bit BCH polymod one symbol at a time.
// Start, prefix, data and verify transactions each return one result; a
// transaction is accepted while the previous result still sits in the output
// register, and is parked in a holding register (input stalls) until that
// register frees up. End of prefix walks the N stored prefix characters (up
// to 84): the low five bits of each prefix character live in an 84 x 5 RAM
// with a registered read port; on acceptance the zero is fed and the first
// read is issued, the walk feeds one entry per cycle, and then the single
// result is posted once the output is free.
// Finish-encode loads a copy of the checksum, runs six zero-feeds on it, then
// emits the six checksum characters one per cycle as the output drains; last
// marks the sixth. Mode seven is dropped with no result. Status codes: 0 ok,
// 1 invalid character / earlier error, 2 checksum mismatch, 3 fewer than six
// data symbols, 4 prefix too long.
module bech32_checksum_engine (
    input  logic      clk,
    input  logic      rst_n,
    bce_in_if.sink    in_ch,
    bce_out_if.source out_ch
);
    import bce_pkg::*;

    ctrl_cmd_t cmd;    // controller commands
    dp_stat_t  stat;   // datapath status flags

    // sequencer: accept, park, prefix walk, finish sequence
    bce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_mode  (in_ch.mode),
        .stat     (stat),
        .in_ready (in_ch.ready),
        .cmd      (cmd)
    );

    // checksum, counters, prefix RAM and the output register
    bce_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_mode    (in_ch.mode),
        .in_char    (in_ch.char_in),
        .in_value   (in_ch.value_in),
        .out_ready  (out_ch.ready),
        .stat       (stat),
        .out_valid  (out_ch.valid),
        .out_char   (out_ch.char_out),
        .out_value  (out_ch.value_out),
        .out_status (out_ch.status),
        .out_last   (out_ch.last)
    );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import bce_pkg::*;

    // Expected content of one output transaction
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic [SYM_W-1:0]  sym;
        status_t           st;
        logic              tail;
    } emitted_sym_t;

    // Scoreboard: tracks the checksum state of the string being streamed,
    // predicts the output transactions of every accepted input transaction
    // and checks them in order.
    class checksum_scoreboard;
        localparam logic [255:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

        logic [CHK_W-1:0] checksum_acc;
        logic [SYM_W-1:0] hrp_low [PREFIX_MAX];
        int unsigned      hrp_len;
        int unsigned      data_len;
        bit               seen_error;
        logic [SYM_W-1:0] enc_syms [FIN_STEPS];
        emitted_sym_t     expected_q [$];
        int unsigned      mismatch_cnt;

        function new();
            checksum_acc = 30'd1;
            hrp_len      = 0;
            data_len     = 0;
            seen_error   = 1'b0;
            mismatch_cnt = 0;
        endfunction

        function logic [CHAR_W-1:0] char_of(logic [SYM_W-1:0] s);
            logic [7:0] b;
            b = ALPHABET[8*(31 - int'(s)) +: 8];
            return b[CHAR_W-1:0];
        endfunction

        // -1 when the character is not in the alphabet
        function int index_of(logic [CHAR_W-1:0] c);
            for (int i = 0; i < 32; i++) begin
                if (ALPHABET[8*(31 - i) +: 8] == {1'b0, c}) begin
                    return i;
                end
            end
            return -1;
        endfunction

        // One BCH step: shift in a symbol, fold the five bits shifted out
        function logic [CHK_W-1:0] bch_step(logic [CHK_W-1:0] acc, logic [SYM_W-1:0] s);
            logic [CHK_W-1:0] nxt;
            nxt = {acc[24:0], s};
            if (acc[25]) nxt ^= 30'h3b6a57b2;
            if (acc[26]) nxt ^= 30'h26508e6d;
            if (acc[27]) nxt ^= 30'h1ea119fa;
            if (acc[28]) nxt ^= 30'h3d4233dd;
            if (acc[29]) nxt ^= 30'h2a1462b3;
            return nxt;
        endfunction

        function void queue_result(logic [CHAR_W-1:0] ch, logic [SYM_W-1:0] sym,
                                   status_t st, logic tail);
            emitted_sym_t r;
            r.ch   = ch;
            r.sym  = sym;
            r.st   = st;
            r.tail = tail;
            expected_q = {expected_q, r};
        endfunction

        function void bump_data();
            if (data_len < 255) data_len++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Called on every accepted input transaction
        function void note_input(mode_t op, logic [CHAR_W-1:0] c, logic [SYM_W-1:0] v);
            logic [CHK_W-1:0] tmp;
            int               idx;
            status_t          st;
            case (op)
                MODE_START: begin
                    checksum_acc = 30'd1;
                    hrp_len      = 0;
                    data_len     = 0;
                    seen_error   = 1'b0;
                    queue_result('0, '0, ST_OK, 1'b1);
                end
                MODE_PREFIX: begin
                    if (hrp_len >= PREFIX_MAX) begin
                        seen_error = 1'b1;
                        queue_result('0, '0, ST_PREFIX_LONG, 1'b1);
                    end else begin
                        checksum_acc     = bch_step(checksum_acc, {3'b000, c[6:5]});
                        hrp_low[hrp_len] = c[4:0];
                        hrp_len++;
                        queue_result('0, '0, ST_OK, 1'b1);
                    end
                end
                MODE_END_PREFIX: begin
                    checksum_acc = bch_step(checksum_acc, '0);
                    for (int i = 0; i < hrp_len; i++) begin
                        checksum_acc = bch_step(checksum_acc, hrp_low[i]);
                    end
                    queue_result('0, '0, ST_OK, 1'b1);
                end
                MODE_DATA_VALUE: begin
                    checksum_acc = bch_step(checksum_acc, v);
                    bump_data();
                    queue_result(char_of(v), v, ST_OK, 1'b1);
                end
                MODE_DATA_CHAR: begin
                    idx = index_of(c);
                    if (idx < 0) begin
                        seen_error = 1'b1;
                        queue_result(c, '0, ST_BAD_CHAR, 1'b1);
                    end else begin
                        checksum_acc = bch_step(checksum_acc, SYM_W'(idx));
                        bump_data();
                        queue_result(c, SYM_W'(idx), ST_OK, 1'b1);
                    end
                end
                MODE_FINISH_ENC: begin
                    tmp = checksum_acc;
                    for (int k = 0; k < FIN_STEPS; k++) tmp = bch_step(tmp, '0);
                    tmp ^= 30'd1;
                    st = seen_error ? ST_BAD_CHAR : ST_OK;
                    for (int k = 0; k < FIN_STEPS; k++) begin
                        enc_syms[k] = tmp[5*(5-k) +: 5];
                        queue_result(char_of(enc_syms[k]), enc_syms[k], st, k == FIN_STEPS - 1);
                    end
                end
                MODE_FINISH_VER: begin
                    if (seen_error)                  st = ST_BAD_CHAR;
                    else if (data_len < MIN_DATA)    st = ST_SHORT;
                    else if (checksum_acc != 30'd1)  st = ST_MISMATCH;
                    else                             st = ST_OK;
                    queue_result('0, '0, st, 1'b1);
                end
                default: ;  // dropped, nothing comes out
            endcase
        endfunction

        task report_mismatch(string msg);
            mismatch_cnt++;
            if (mismatch_cnt <= 50) $display("[%0t] ERROR: %s", $time, msg);
        endtask

        // Called on every accepted output transaction
        task check_result(logic [CHAR_W-1:0] ch, logic [SYM_W-1:0] sym,
                          logic [STATUS_W-1:0] st, logic tail);
            emitted_sym_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("output transaction with nothing outstanding");
                return;
            end
            want = expected_q.pop_front();
            if (ch !== want.ch)
                report_mismatch($sformatf("char_out %0h, want %0h", ch, want.ch));
            if (sym !== want.sym)
                report_mismatch($sformatf("value_out %0d, want %0d", sym, want.sym));
            if (st !== want.st)
                report_mismatch($sformatf("status %0d, want %0d", st, want.st));
            if (tail !== want.tail)
                report_mismatch($sformatf("last %0b, want %0b", tail, want.tail));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    bce_in_if  in_ch ();
    bce_out_if out_ch ();

    bech32_checksum_engine DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #4 clk = ~clk;

    checksum_scoreboard sb;
    int items_sent = 0;   // mode seven not counted, the block just drops it
    int send_calm  = 0;

    // Per-transaction random wait, with occasional runs of back-to-back traffic
    function automatic int draw_pause(ref int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // Offer one input transaction; returns at the edge where it is accepted.
    // Valid is held across back-to-back transactions, lowered only for a gap.
    task automatic send_item(mode_t op, logic [CHAR_W-1:0] c, logic [SYM_W-1:0] v);
        int gap;
        gap = draw_pause(send_calm);
        @(negedge clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.mode     <= op;
        in_ch.char_in  <= c;
        in_ch.value_in <= v;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_input(op, c, v);
        if (op != MODE_NONE) items_sent++;
    endtask

    // Prefix characters over the full 7-bit range, so all four upper parts show up
    task automatic send_prefix(int n);
        repeat (n) send_item(MODE_PREFIX, CHAR_W'($urandom_range(0, 127)),
                             SYM_W'($urandom_range(0, 31)));
    endtask

    // Data symbols, a mix of raw values and alphabet characters; with allow_bad
    // an occasional arbitrary character, mostly outside the alphabet
    task automatic send_data(int n, bit allow_bad);
        logic [SYM_W-1:0] s;
        repeat (n) begin
            s = SYM_W'($urandom_range(0, 31));
            if (allow_bad && $urandom_range(0, 11) == 0)
                send_item(MODE_DATA_CHAR, CHAR_W'($urandom_range(0, 127)), s);
            else if ($urandom_range(0, 1) == 0)
                send_item(MODE_DATA_VALUE, CHAR_W'($urandom_range(0, 127)), s);
            else
                send_item(MODE_DATA_CHAR, sb.char_of(s), SYM_W'($urandom_range(0, 31)));
        end
    endtask

    // Feed the six checksum symbols just predicted back in, so a following
    // verify transaction sees a valid string
    task automatic send_checksum_back();
        logic [SYM_W-1:0] syms [FIN_STEPS];
        syms = sb.enc_syms;
        for (int k = 0; k < FIN_STEPS; k++) begin
            if ($urandom_range(0, 1) == 0)
                send_item(MODE_DATA_VALUE, CHAR_W'($urandom_range(0, 127)), syms[k]);
            else
                send_item(MODE_DATA_CHAR, sb.char_of(syms[k]), SYM_W'($urandom_range(0, 31)));
        end
    endtask

    // One complete string: start, prefix, separator, data, checksum, check
    task automatic random_string();
        int n_data;
        send_item(MODE_START, CHAR_W'($urandom_range(0, 127)), SYM_W'($urandom_range(0, 31)));
        send_prefix($urandom_range(1, 10));
        send_item(MODE_END_PREFIX, CHAR_W'($urandom_range(0, 127)), SYM_W'($urandom_range(0, 31)));
        if ($urandom_range(0, 9) == 0)
            send_item(MODE_END_PREFIX, '0, '0);
        n_data = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 5) : $urandom_range(6, 14);
        send_data(n_data, 1'b1);
        if ($urandom_range(0, 15) == 0)
            send_item(MODE_NONE, CHAR_W'($urandom_range(0, 127)), SYM_W'($urandom_range(0, 31)));
        send_item(MODE_FINISH_ENC, CHAR_W'($urandom_range(0, 127)), SYM_W'($urandom_range(0, 31)));
        if ($urandom_range(0, 9) < 6)
            send_checksum_back();
        send_item(MODE_FINISH_VER, CHAR_W'($urandom_range(0, 127)), SYM_W'($urandom_range(0, 31)));
    endtask

    // Output side: random stalls per transaction, plus one long hold-off
    // while the sender keeps offering, so the engine backs up into its input.
    initial begin : result_sink
        int pause;
        int n_seen;
        int calm;
        out_ch.ready = 1'b0;
        n_seen = 0;
        calm   = 0;
        @(posedge rst_n);
        forever begin
            pause = draw_pause(calm);
            if (n_seen == 60) pause = 300;
            @(negedge clk);
            if (pause > 0) begin
                out_ch.ready <= 1'b0;
                repeat (pause) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
            sb.check_result(out_ch.char_out, out_ch.value_out, out_ch.status, out_ch.last);
            n_seen++;
        end
    end

    initial begin : stimulus
        int rand_goal;
        sb = new();
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.mode     = MODE_START;
        in_ch.char_in  = '0;
        in_ch.value_in = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: data before any start acts on the reset state; mode seven
        // is dropped; prefix extremes; repeated separator; value and char
        // extremes; characters outside the alphabet (upper case, 0x7f)
        send_item(MODE_DATA_VALUE, 7'h7f, 5'd31);
        send_item(MODE_NONE, 7'h7f, 5'd31);
        send_item(MODE_START, 7'h00, 5'd0);
        send_item(MODE_PREFIX, 7'h7f, 5'd0);
        send_item(MODE_PREFIX, 7'h00, 5'd31);
        send_item(MODE_PREFIX, 7'h62, 5'd0);
        send_item(MODE_END_PREFIX, 7'h00, 5'd0);
        send_item(MODE_END_PREFIX, 7'h7f, 5'd31);
        send_item(MODE_DATA_VALUE, 7'h00, 5'd0);
        send_item(MODE_DATA_VALUE, 7'h00, 5'd31);
        send_item(MODE_DATA_CHAR, 7'h71, 5'd0);     // 'q'
        send_item(MODE_DATA_CHAR, 7'h6c, 5'd0);     // 'l'
        send_item(MODE_DATA_CHAR, 7'h51, 5'd0);     // 'Q', rejected
        send_item(MODE_DATA_CHAR, 7'h7f, 5'd0);     // rejected
        // error sticks through both finishes
        send_item(MODE_FINISH_VER, 7'h00, 5'd0);
        send_item(MODE_FINISH_ENC, 7'h00, 5'd0);
        // too few data symbols
        send_item(MODE_START, 7'h00, 5'd0);
        send_item(MODE_FINISH_VER, 7'h00, 5'd0);
        // clean round trip: encode, feed the checksum back, verify passes
        send_item(MODE_START, 7'h00, 5'd0);
        send_item(MODE_PREFIX, 7'h61, 5'd0);
        send_item(MODE_END_PREFIX, 7'h00, 5'd0);
        send_item(MODE_FINISH_ENC, 7'h00, 5'd0);
        send_checksum_back();
        send_item(MODE_FINISH_VER, 7'h00, 5'd0);

        // Prefix overflow: 84 stored, the two beyond are refused; the
        // separator then walks the full store
        send_item(MODE_START, 7'h00, 5'd0);
        send_prefix(PREFIX_MAX + 2);
        send_item(MODE_END_PREFIX, 7'h00, 5'd0);
        send_data(6, 1'b0);
        send_item(MODE_FINISH_ENC, 7'h00, 5'd0);
        send_item(MODE_FINISH_VER, 7'h00, 5'd0);

        // Data counter: verify around the six-symbol floor and around 255,
        // where the counter must saturate rather than wrap
        send_item(MODE_START, 7'h00, 5'd0);
        for (int k = 1; k <= 261; k++) begin
            send_item(MODE_DATA_VALUE, CHAR_W'($urandom_range(0, 127)),
                      SYM_W'($urandom_range(0, 31)));
            if (k == 5 || k == 6 || k == 255 || k == 256 || k == 257 || k == 261)
                send_item(MODE_FINISH_VER, 7'h00, 5'd0);
        end
        send_item(MODE_FINISH_ENC, 7'h00, 5'd0);

        // Random: mostly complete strings, some unstructured transactions
        rand_goal = items_sent + 130;
        while (items_sent < rand_goal) begin
            if ($urandom_range(0, 9) < 7) begin
                random_string();
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(mode_t'($urandom_range(0, 7)), CHAR_W'($urandom_range(0, 127)),
                              SYM_W'($urandom_range(0, 31)));
            end
        end

        @(negedge clk);
        in_ch.valid <= 1'b0;

        // Drain, then leave room for a separator walk to show a stray result
        while (sb.pending() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
